>>> hdl/mmix_pkg.sv
// mmix_pkg: shared constants, widths, mix tables and helpers for the motor mixer
// no dependencies; used by the interfaces and the mixer core
package mmix_pkg;

  localparam int FRAC_BITS   = 14;
  localparam int ONE_Q       = 1 << FRAC_BITS;
  localparam int MOTOR_COUNT = 4;
  localparam int IDX_W       = $clog2(MOTOR_COUNT);

  // field widths
  localparam int CMD_W  = 16;
  localparam int MV_W   = 16;
  localparam int PLS_W  = 12;
  localparam int REG15_W = 15;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  // internal widths
  localparam int MIX_W = FRAC_BITS + 4;   // signed mix, -3..4 in Q
  localparam int POS_W = FRAC_BITS + 3;   // positive mix, up to 4.0
  localparam int LVL_W = FRAC_BITS + 1;   // 0..1.0
  localparam int CRV_W = FRAC_BITS + 5;   // curve output, up to 16.0
  localparam int SQ_W  = 2 * POS_W;
  localparam int MA_W  = POS_W + LVL_W;
  localparam int SUM_W = 3 * FRAC_BITS + 8;
  localparam int NUM_W = MV_W + FRAC_BITS;
  localparam int CMP_W = CRV_W + 1;
  localparam int CR_W  = CRV_W + LVL_W;
  localparam int PRD_W = LVL_W + PLS_W;

  // battery ratio limits and divider shape
  localparam int RATIO_LO = (ONE_Q * 4) / 5;
  localparam int RATIO_HI = (ONE_Q * 6) / 5;
  localparam int QUO_W    = $clog2(RATIO_HI - RATIO_LO + 1);
  localparam int DIV_STG  = (QUO_W + 1) / 2;

  localparam int LOSS_T  = ONE_Q / 1000;
  localparam int LIMIT_T = ONE_Q / 10;

  localparam logic signed [MIX_W-1:0] ONE_S     = MIX_W'(ONE_Q);
  localparam logic signed [MIX_W-1:0] NEG_ONE_S = -MIX_W'(ONE_Q);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PMIN    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PMAX    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EXPO    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COMP_ON = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_NOMINAL = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FLOOR   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_CEIL    = 3'd7;

  // mix factor codes
  localparam logic [1:0] MX_ZERO = 2'b00;
  localparam logic [1:0] MX_POS  = 2'b01;
  localparam logic [1:0] MX_NEG  = 2'b11;

  // [frame][motor], frame 0 quad X, 1 quad plus
  localparam logic [1:0] MIX_ROLL [2][MOTOR_COUNT] = '{
    '{MX_POS, MX_POS, MX_NEG, MX_NEG}, '{MX_ZERO, MX_POS, MX_ZERO, MX_NEG}};
  localparam logic [1:0] MIX_PITCH [2][MOTOR_COUNT] = '{
    '{MX_NEG, MX_POS, MX_POS, MX_NEG}, '{MX_NEG, MX_ZERO, MX_POS, MX_ZERO}};
  localparam logic [1:0] MIX_YAW [2][MOTOR_COUNT] = '{
    '{MX_POS, MX_NEG, MX_POS, MX_NEG}, '{MX_POS, MX_NEG, MX_POS, MX_NEG}};

  // one pipeline stage's payload; each stage fills the fields it owns
  typedef struct packed {
    logic                              armed;
    logic                              enabled;
    logic                              comp;
    logic [MOTOR_COUNT-1:0][POS_W-1:0] mpos;
    logic [MOTOR_COUNT-1:0][SQ_W-1:0]  msq;
    logic [MOTOR_COUNT-1:0][MA_W-1:0]  mlin;
    logic [MOTOR_COUNT-1:0][CRV_W-1:0] crv;
    logic [MOTOR_COUNT-1:0][CR_W-1:0]  crat;
    logic [MOTOR_COUNT-1:0][LVL_W-1:0] lvl;
    logic [MOTOR_COUNT-1:0][PRD_W-1:0] prod;
    logic                              loss;
    logic                              limit;
    logic [NUM_W-1:0]                  rem;
    logic [MV_W-1:0]                   den;
    logic [NUM_W-1:0]                  plo;
    logic [NUM_W:0]                    phi;
    logic                              sat_lo;
    logic                              sat_hi;
    logic [QUO_W-1:0]                  quo;
    logic [LVL_W-1:0]                  ratio;
  } st_t;

  function automatic logic signed [MIX_W-1:0] clamp_cmd(input logic [CMD_W-1:0] v,
                                                        input logic unipolar);
    logic signed [MIX_W-1:0] x;
    x = MIX_W'($signed(v));
    if (x > ONE_S) x = ONE_S;
    else if (unipolar && x < 0) x = '0;
    else if (!unipolar && x < NEG_ONE_S) x = NEG_ONE_S;
    return x;
  endfunction

  function automatic logic signed [MIX_W-1:0] mix_term(input logic [1:0] code,
                                                       input logic signed [MIX_W-1:0] x);
    logic signed [MIX_W-1:0] r;
    case (code)
      MX_POS:  r = x;
      MX_NEG:  r = -x;
      default: r = '0;
    endcase
    return r;
  endfunction

  // saturate a Q register value to one
  function automatic logic [LVL_W-1:0] sat_one(input logic [REG15_W-1:0] v);
    logic [LVL_W-1:0] r;
    if ({1'b0, v} > (REG15_W + 1)'(ONE_Q)) r = LVL_W'(ONE_Q);
    else r = LVL_W'(v);
    return r;
  endfunction

endpackage

>>> hdl/mmix_in_if.sv
// mmix_in_if: command input channel, valid/ready plus one command transaction
// depends on mmix_pkg
interface mmix_in_if import mmix_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  roll_cmd;
  logic [CMD_W-1:0]  pitch_cmd;
  logic [CMD_W-1:0]  yaw_cmd;
  logic [CMD_W-1:0]  throttle_cmd;
  logic [MV_W-1:0]   battery_mv;
  logic              armed;
  logic              output_enabled;

  modport source (output valid, roll_cmd, pitch_cmd, yaw_cmd, throttle_cmd, battery_mv,
                  armed, output_enabled, input ready);
  modport sink (input valid, roll_cmd, pitch_cmd, yaw_cmd, throttle_cmd, battery_mv,
                armed, output_enabled, output ready);
endinterface

>>> hdl/mmix_out_if.sv
// mmix_out_if: motor result channel, valid/ready plus one per-motor transaction
// depends on mmix_pkg
interface mmix_out_if import mmix_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  motor_index;
  logic [PLS_W-1:0]  pulse_us;
  logic [LVL_W-1:0]  output_level;
  logic              pulse_write;
  logic              thrust_loss;
  logic              throttle_limit;
  logic              last_motor;

  modport source (output valid, motor_index, pulse_us, output_level, pulse_write,
                  thrust_loss, throttle_limit, last_motor, input ready);
  modport sink (input valid, motor_index, pulse_us, output_level, pulse_write,
                thrust_loss, throttle_limit, last_motor, output ready);
endinterface

>>> hdl/mmix_cfg_if.sv
// mmix_cfg_if: register write channel, valid/ready plus index and data
// depends on mmix_pkg
interface mmix_cfg_if import mmix_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DAT_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> hdl/multirotor_motor_mixer_core.sv
// multirotor_motor_mixer_core: pipelined quad motor mixer with expo, battery
// compensation, limits and pwm scaling; depends on mmix_pkg and the mmix_*_if interfaces
//
//   channel   dir   carries
//   in_ch     in    one command transaction: roll/pitch/yaw/throttle, battery, flags
//   out_ch    out   four motor transactions per command, last_motor on the fourth
//   cfg_ch    in    register write: index, data (always ready)
//
// a command occupies the output for four motor transactions: the result serializer emits
// one motor per cycle while out_ch is ready, and loads the next command as the last motor is taken
// the pipeline ahead of the serializer has NST stages (12 pipeline stages at q14)
// rst_n (sync, active low) clears valid bits, the serializer and the registers
// a stall on out_ch freezes the whole pipeline; bubbles and data hold in place
module multirotor_motor_mixer_core import mmix_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  mmix_in_if.sink    in_ch,
  mmix_out_if.source out_ch,
  mmix_cfg_if.sink   cfg_ch
);

  // stage map: mix, square, curve + divider steps, ratio, clamp, pulse
  localparam int ST_MIX   = 0;
  localparam int ST_SQ    = 1;
  localparam int ST_CURVE = 2;
  localparam int ST_RATIO = ST_CURVE + DIV_STG;
  localparam int ST_CLAMP = ST_RATIO + 1;
  localparam int ST_PULSE = ST_CLAMP + 1;
  localparam int NST      = ST_PULSE + 1;

  // configuration registers
  logic               frame_r;
  logic [PLS_W-1:0]   pmin_r;
  logic [PLS_W-1:0]   pmax_r;
  logic [REG15_W-1:0] expo_r;
  logic               comp_on_r;
  logic [MV_W-1:0]    nominal_r;
  logic [REG15_W-1:0] floor_r;
  logic [REG15_W-1:0] ceil_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_r   <= 1'b0;
      pmin_r    <= PLS_W'(1000);
      pmax_r    <= PLS_W'(2000);
      expo_r    <= REG15_W'(10650);
      comp_on_r <= 1'b1;
      nominal_r <= MV_W'(12600);
      floor_r   <= '0;
      ceil_r    <= REG15_W'(ONE_Q);
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_FRAME:   frame_r   <= cfg_ch.data[0];
        REG_PMIN:    pmin_r    <= cfg_ch.data[PLS_W-1:0];
        REG_PMAX:    pmax_r    <= cfg_ch.data[PLS_W-1:0];
        REG_EXPO:    expo_r    <= cfg_ch.data[REG15_W-1:0];
        REG_COMP_ON: comp_on_r <= cfg_ch.data[0];
        REG_NOMINAL: nominal_r <= cfg_ch.data[MV_W-1:0];
        REG_FLOOR:   floor_r   <= cfg_ch.data[REG15_W-1:0];
        REG_CEIL:    ceil_r    <= cfg_ch.data[REG15_W-1:0];
        default: ;
      endcase
    end
  end

  // derived settings; the user keeps them static while commands are in flight, the block does not enforce it
  logic [LVL_W-1:0] expo_sat;
  logic [LVL_W-1:0] lin_gain;
  logic [LVL_W-1:0] lo_sat;
  logic [LVL_W-1:0] hi_sat;
  logic [PLS_W-1:0] span;

  assign expo_sat = sat_one(expo_r);
  assign lin_gain = LVL_W'(ONE_Q) - expo_sat;
  assign lo_sat   = sat_one(floor_r);
  assign hi_sat   = sat_one(ceil_r);
  assign span     = (pmax_r >= pmin_r) ? (pmax_r - pmin_r) : '0;

  // pipeline
  st_t  st_r   [NST];
  st_t  st_nxt [NST];
  logic vld_r  [NST];

  // result serializer
  logic                  busy_r;
  logic [IDX_W-1:0]      idx_r;
  logic [PLS_W-1:0]      pulse_r [MOTOR_COUNT];
  logic [LVL_W-1:0]      level_r [MOTOR_COUNT];
  logic                  write_r;
  logic                  loss_r;
  logic                  limit_r;

  logic out_fire;
  logic done;
  logic adv;
  logic load;

  assign out_fire = busy_r && out_ch.ready;
  assign done     = out_fire && (idx_r == IDX_W'(MOTOR_COUNT - 1));
  assign adv      = !busy_r || done;
  assign load     = adv && vld_r[NST-1];
  assign in_ch.ready = adv;

  always_comb begin
    st_t                     s;
    logic signed [MIX_W-1:0] roll_c, pitch_c, yaw_c, thr_c, m;
    logic [SUM_W-1:0]        sum;
    logic [NUM_W:0]          dsh;
    logic [CMP_W-1:0]        v;
    logic [CMP_W-1:0]        diff;
    int                      bk;

    // mix stage, straight from the input transaction
    s = '0;
    roll_c  = clamp_cmd(in_ch.roll_cmd, 1'b0);
    pitch_c = clamp_cmd(in_ch.pitch_cmd, 1'b0);
    yaw_c   = clamp_cmd(in_ch.yaw_cmd, 1'b0);
    thr_c   = clamp_cmd(in_ch.throttle_cmd, 1'b1);
    s.armed   = in_ch.armed;
    s.enabled = in_ch.output_enabled;
    s.comp    = comp_on_r && (in_ch.battery_mv != '0) && (nominal_r != '0);
    for (int i = 0; i < MOTOR_COUNT; i++) begin
      m = thr_c + mix_term(MIX_ROLL[frame_r][i], roll_c)
                + mix_term(MIX_PITCH[frame_r][i], pitch_c)
                + mix_term(MIX_YAW[frame_r][i], yaw_c);
      s.mpos[i] = (m > 0) ? m[POS_W-1:0] : '0;
    end
    s.rem = {nominal_r, {FRAC_BITS{1'b0}}};
    s.den = in_ch.battery_mv;
    s.plo = NUM_W'(in_ch.battery_mv * LVL_W'(RATIO_LO));
    s.phi = (NUM_W + 1)'(in_ch.battery_mv * (LVL_W + 1)'(RATIO_HI + 1));
    st_nxt[ST_MIX] = s;

    for (int k = 1; k < NST; k++) begin
      s = st_r[k-1];

      if (k == ST_SQ) begin
        for (int i = 0; i < MOTOR_COUNT; i++) begin
          s.msq[i]  = s.mpos[i] * s.mpos[i];
          s.mlin[i] = s.mpos[i] * lin_gain;
        end
        // ratio outside 0.8..1.2 saturates; inside, divide the excess over the low bound
        s.sat_lo = s.rem < s.plo;
        s.sat_hi = {1'b0, s.rem} >= s.phi;
        s.rem    = s.rem - s.plo;
        s.quo    = '0;
      end

      if (k == ST_CURVE) begin
        // x*(1-e) + x*x*e, both terms scaled to q(3*frac)
        for (int i = 0; i < MOTOR_COUNT; i++) begin
          sum = (SUM_W'(s.mlin[i]) << FRAC_BITS) + SUM_W'(s.msq[i] * expo_sat);
          s.crv[i] = sum[2*FRAC_BITS +: CRV_W];
        end
      end

      if (k >= ST_CURVE && k < ST_CURVE + DIV_STG) begin
        // two restoring quotient bits per stage
        for (int t = 0; t < 2; t++) begin
          bk = QUO_W - 1 - 2 * (k - ST_CURVE) - t;
          if (bk >= 0) begin
            dsh = (NUM_W + 1)'(s.den) << bk;
            if ({1'b0, s.rem} >= dsh) begin
              s.rem = s.rem - dsh[NUM_W-1:0];
              s.quo = s.quo | (QUO_W'(1) << bk);
            end
          end
        end
      end

      if (k == ST_RATIO) begin
        if (s.sat_lo) s.ratio = LVL_W'(RATIO_LO);
        else if (s.sat_hi) s.ratio = LVL_W'(RATIO_HI);
        else s.ratio = LVL_W'(RATIO_LO) + LVL_W'(s.quo);
        for (int i = 0; i < MOTOR_COUNT; i++) begin
          s.crat[i] = s.crv[i] * s.ratio;
        end
      end

      if (k == ST_CLAMP) begin
        s.loss = 1'b0;
        for (int i = 0; i < MOTOR_COUNT; i++) begin
          v = s.comp ? s.crat[i][FRAC_BITS +: CMP_W] : CMP_W'(s.crv[i]);
          if (v < CMP_W'(lo_sat)) s.lvl[i] = lo_sat;
          else if (v > CMP_W'(hi_sat)) s.lvl[i] = hi_sat;
          else s.lvl[i] = v[LVL_W-1:0];
          diff = (v > CMP_W'(s.lvl[i])) ? (v - CMP_W'(s.lvl[i])) : (CMP_W'(s.lvl[i]) - v);
          if (diff > CMP_W'(LOSS_T)) s.loss = 1'b1;
        end
      end

      if (k == ST_PULSE) begin
        s.limit = 1'b1;
        for (int i = 0; i < MOTOR_COUNT; i++) begin
          if ((LVL_W + 1)'(s.lvl[i]) + (LVL_W + 1)'(LIMIT_T) < (LVL_W + 1)'(hi_sat))
            s.limit = 1'b0;
          s.prod[i] = s.lvl[i] * span;
        end
      end

      st_nxt[k] = s;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NST; k++) vld_r[k] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_ch.valid;
      for (int k = 1; k < NST; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < NST; k++) st_r[k] <= st_nxt[k];
    end
  end

  // serializer control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else if (load) begin
      busy_r <= 1'b1;
      idx_r  <= '0;
    end else if (out_fire) begin
      busy_r <= !done;
      idx_r  <= idx_r + IDX_W'(1);
    end
  end

  // serializer data; disarmed or disabled forces minimum pulse and zero level
  always_ff @(posedge clk) begin
    if (load) begin
      if (st_r[NST-1].armed && st_r[NST-1].enabled) begin
        for (int i = 0; i < MOTOR_COUNT; i++) begin
          pulse_r[i] <= pmin_r + st_r[NST-1].prod[i][FRAC_BITS +: PLS_W];
          level_r[i] <= st_r[NST-1].lvl[i];
        end
        write_r <= 1'b1;
        loss_r  <= st_r[NST-1].loss;
        limit_r <= st_r[NST-1].limit;
      end else begin
        for (int i = 0; i < MOTOR_COUNT; i++) begin
          pulse_r[i] <= pmin_r;
          level_r[i] <= '0;
        end
        write_r <= st_r[NST-1].enabled;
        loss_r  <= 1'b0;
        limit_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid          = busy_r;
  assign out_ch.motor_index    = idx_r;
  assign out_ch.pulse_us       = pulse_r[idx_r];
  assign out_ch.output_level   = level_r[idx_r];
  assign out_ch.pulse_write    = write_r;
  assign out_ch.thrust_loss    = loss_r;
  assign out_ch.throttle_limit = limit_r;
  assign out_ch.last_motor     = (idx_r == IDX_W'(MOTOR_COUNT - 1));

endmodule

>>> dv/mmix_tb_if.sv
// mmix_tb_if: testbench-side channel bundle note; the block's own interfaces
// (mmix_in_if, mmix_out_if, mmix_cfg_if) come from hdl and depend on mmix_pkg
// this file holds only a small helper interface for shared run statistics
interface mmix_tb_stat_if;
  int unsigned commands_sent;
  int unsigned motors_checked;
endinterface

>>> dv/tb_top.sv
// tb_top: self-checking testbench for multirotor_motor_mixer_core
// depends on mmix_pkg, the mmix_*_if interfaces and the core; predicts each
// motor transaction in fixed point and compares it with the block's output
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import mmix_pkg::*;

  logic clk;
  logic rst_n;

  mmix_in_if  in_ch ();
  mmix_out_if out_ch ();
  mmix_cfg_if cfg_ch ();
  mmix_tb_stat_if stat ();

  multirotor_motor_mixer_core uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source),
    .cfg_ch (cfg_ch.sink)
  );

  // one expected motor transaction
  typedef struct {
    logic [IDX_W-1:0] motor_index;
    logic [PLS_W-1:0] pulse_us;
    logic [LVL_W-1:0] output_level;
    logic             pulse_write;
    logic             thrust_loss;
    logic             throttle_limit;
    logic             last_motor;
  } motor_res_t;

  motor_res_t motor_expect_q[$];

  // shadow copy of the register file
  logic                 sh_frame;
  logic [PLS_W-1:0]     sh_pmin;
  logic [PLS_W-1:0]     sh_pmax;
  logic [REG15_W-1:0]   sh_expo;
  logic                 sh_comp_on;
  logic [MV_W-1:0]      sh_nominal;
  logic [REG15_W-1:0]   sh_floor;
  logic [REG15_W-1:0]   sh_ceil;

  int unsigned mismatches;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned hold_off;
  int unsigned post_cycles;
  int unsigned n_loss, n_limit, n_disarmed;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // maps a mix factor code to +1, -1 or 0; quad X factors in frame 0, plus factors in frame 1
  function automatic int mix_factor(input logic [1:0] code);
    if (code == MX_POS) return 1;
    if (code == MX_NEG) return -1;
    return 0;
  endfunction

  function automatic longint clamp_l(input longint v, input longint lo, input longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // works out the four motor transactions for one command
  task automatic predict_motors(input logic [CMD_W-1:0] roll_v, pitch_v, yaw_v, thr_v,
                                input logic [MV_W-1:0] batt_v, input logic arm_v,
                                input logic en_v);
    longint one, roll, pitch, yaw, thr, e, lo, hi, ratio, span, m, c, pre, t;
    longint lvl[MOTOR_COUNT];
    logic comp, loss, limit;
    motor_res_t r;
    one   = ONE_Q;
    roll  = clamp_l(longint'($signed(roll_v)), -one, one);
    pitch = clamp_l(longint'($signed(pitch_v)), -one, one);
    yaw   = clamp_l(longint'($signed(yaw_v)), -one, one);
    thr   = clamp_l(longint'($signed(thr_v)), 0, one);
    span  = (sh_pmax >= sh_pmin) ? longint'(sh_pmax) - longint'(sh_pmin) : 0;
    loss  = 1'b0;
    limit = 1'b1;
    if (!arm_v || !en_v) begin
      n_disarmed++;
      for (int i = 0; i < MOTOR_COUNT; i++) begin
        r.motor_index = IDX_W'(i);
        r.pulse_us = sh_pmin;
        r.output_level = '0;
        r.pulse_write = en_v;
        r.thrust_loss = 1'b0;
        r.throttle_limit = 1'b0;
        r.last_motor = (i == MOTOR_COUNT - 1);
        motor_expect_q.push_back(r);
      end
      return;
    end
    e  = clamp_l(longint'(sh_expo), 0, one);
    lo = clamp_l(longint'(sh_floor), 0, one);
    hi = clamp_l(longint'(sh_ceil), 0, one);
    comp = sh_comp_on && batt_v != 0 && sh_nominal != 0;
    ratio = 0;
    if (comp) begin
      ratio = (longint'(sh_nominal) << FRAC_BITS) / longint'(batt_v);
      ratio = clamp_l(ratio, RATIO_LO, RATIO_HI);
    end
    for (int i = 0; i < MOTOR_COUNT; i++) begin
      m = thr + mix_factor(MIX_ROLL[sh_frame][i]) * roll
              + mix_factor(MIX_PITCH[sh_frame][i]) * pitch
              + mix_factor(MIX_YAW[sh_frame][i]) * yaw;
      // expo curve, non-positive mix gives zero thrust
      if (m <= 0) c = 0;
      else if (e == 0) c = m;
      else c = (m * (one - e) * one + m * m * e) >>> (2 * FRAC_BITS);
      if (comp) c = (c * ratio) >>> FRAC_BITS;
      pre = c;
      if (c < lo) c = lo;
      else if (c > hi) c = hi;
      if (pre - c > LOSS_T || c - pre > LOSS_T) loss = 1'b1;
      lvl[i] = c;
    end
    for (int i = 0; i < MOTOR_COUNT; i++)
      if (lvl[i] < hi - LIMIT_T) limit = 1'b0;
    if (loss) n_loss++;
    if (limit) n_limit++;
    for (int i = 0; i < MOTOR_COUNT; i++) begin
      t = clamp_l(lvl[i], 0, one);
      r.motor_index = IDX_W'(i);
      r.pulse_us = PLS_W'(longint'(sh_pmin) + ((t * span) >>> FRAC_BITS));
      r.output_level = LVL_W'(lvl[i]);
      r.pulse_write = 1'b1;
      r.thrust_loss = loss;
      r.throttle_limit = limit;
      r.last_motor = (i == MOTOR_COUNT - 1);
      motor_expect_q.push_back(r);
    end
  endtask

  // sends one command transaction, with random idle cycles before it
  // valid stays high after the accept so back-to-back commands need no gap
  task automatic send_command(input logic [CMD_W-1:0] roll_v, pitch_v, yaw_v, thr_v,
                              input logic [MV_W-1:0] batt_v, input logic arm_v,
                              input logic en_v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.roll_cmd <= roll_v;
    in_ch.pitch_cmd <= pitch_v;
    in_ch.yaw_cmd <= yaw_v;
    in_ch.throttle_cmd <= thr_v;
    in_ch.battery_mv <= batt_v;
    in_ch.armed <= arm_v;
    in_ch.output_enabled <= en_v;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    // accepted at this edge; prediction uses the registers in force now
    predict_motors(roll_v, pitch_v, yaw_v, thr_v, batt_v, arm_v, en_v);
    stat.commands_sent++;
  endtask

  // valid stays high after the accept; the caller drops it after the last write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      REG_FRAME:   sh_frame   = val[0];
      REG_PMIN:    sh_pmin    = val[PLS_W-1:0];
      REG_PMAX:    sh_pmax    = val[PLS_W-1:0];
      REG_EXPO:    sh_expo    = val[REG15_W-1:0];
      REG_COMP_ON: sh_comp_on = val[0];
      REG_NOMINAL: sh_nominal = val;
      REG_FLOOR:   sh_floor   = val[REG15_W-1:0];
      REG_CEIL:    sh_ceil    = val[REG15_W-1:0];
      default: ;
    endcase
  endtask

  // stops sending and waits for the block to drain before a register write
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (motor_expect_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // random command: mostly in range, sometimes anywhere in the 16-bit field
  function automatic logic [CMD_W-1:0] rand_axis(input logic unipolar);
    int unsigned sel;
    sel = $urandom_range(9);
    if (sel == 0) return CMD_W'($urandom);
    if (sel == 1) return unipolar ? CMD_W'(ONE_Q) : CMD_W'(-ONE_Q);
    if (unipolar) return CMD_W'($urandom_range(ONE_Q));
    return CMD_W'(int'($urandom_range(2 * ONE_Q)) - ONE_Q) >>> 0 == 0 ?
      CMD_W'(0) : CMD_W'(int'($urandom_range(ONE_Q)) - int'($urandom_range(ONE_Q)));
  endfunction

  task automatic send_random(input int n);
    logic [MV_W-1:0] batt;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(3))
        0: batt = MV_W'($urandom);
        1: batt = '0;
        default: batt = MV_W'($urandom_range(16800, 9000));
      endcase
      send_command(rand_axis(1'b0) >>> ($urandom_range(2)), rand_axis(1'b0),
                   rand_axis(1'b0) >>> ($urandom_range(3)), rand_axis(1'b1), batt,
                   $urandom_range(9) != 0, $urandom_range(9) != 0);
    end
  endtask

  // directed extremes and special cases at reset settings
  task automatic test_directed();
    send_command(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'd12600, 1'b1, 1'b1);
    send_command(16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF, 16'hFFFF, 1'b1, 1'b1);
    send_command(16'h8000, 16'h7FFF, 16'h8000, 16'h8000, 16'd1, 1'b1, 1'b1);
    send_command(16'h0000, 16'h0000, 16'h0000, 16'd16384, 16'd12600, 1'b1, 1'b1);
    send_command(16'h0000, 16'h0000, 16'h0000, 16'd16384, 16'd0, 1'b1, 1'b1);
    send_command(16'd4000, 16'hF000, 16'd2000, 16'd8192, 16'd11000, 1'b1, 1'b1);
    // disarmed but enabled, armed but disabled, both off
    send_command(16'd4000, 16'd4000, 16'd4000, 16'd8192, 16'd12000, 1'b0, 1'b1);
    send_command(16'd4000, 16'd4000, 16'd4000, 16'd8192, 16'd12000, 1'b1, 1'b0);
    send_command(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0);
    send_command(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 1'b1, 1'b1);
    send_command(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 1'b1, 1'b1);
    send_command(16'd100, 16'd0, 16'd0, 16'd20, 16'd16000, 1'b1, 1'b1);
  endtask

  // one configuration phase followed by random commands
  task automatic test_setting(input logic frame, input logic [11:0] pmin, pmax,
                              input logic [15:0] expo, input logic comp,
                              input logic [15:0] nom, flo, ceil, input int n);
    wait_idle();
    write_reg(REG_FRAME, 16'(frame));
    write_reg(REG_PMIN, 16'(pmin));
    write_reg(REG_PMAX, 16'(pmax));
    write_reg(REG_EXPO, expo);
    write_reg(REG_COMP_ON, 16'(comp));
    write_reg(REG_NOMINAL, nom);
    write_reg(REG_FLOOR, flo);
    write_reg(REG_CEIL, ceil);
    cfg_ch.valid <= 1'b0;
    send_random(n);
  endtask

  // receiver: random stalls plus an optional long hold-off
  initial begin
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_off != 0) begin
        hold_off <= hold_off - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // result checker
  initial begin
    motor_res_t x;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        if (motor_expect_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%t unexpected motor transaction, index %0d", $realtime,
                     out_ch.motor_index);
        end else begin
          x = motor_expect_q.pop_front();
          stat.motors_checked++;
          if (out_ch.motor_index !== x.motor_index || out_ch.pulse_us !== x.pulse_us ||
              out_ch.output_level !== x.output_level ||
              out_ch.pulse_write !== x.pulse_write ||
              out_ch.thrust_loss !== x.thrust_loss ||
              out_ch.throttle_limit !== x.throttle_limit ||
              out_ch.last_motor !== x.last_motor) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%t mismatch exp idx %0d pw %0d lvl %0d wr %b loss %b lim %b last %b%s",
                       $realtime, x.motor_index, x.pulse_us, x.output_level, x.pulse_write,
                       x.thrust_loss, x.throttle_limit, x.last_motor, "");
            if (mismatches <= 10)
              $display("    got idx %0d pw %0d lvl %0d wr %b loss %b lim %b last %b",
                       out_ch.motor_index, out_ch.pulse_us, out_ch.output_level,
                       out_ch.pulse_write, out_ch.thrust_loss, out_ch.throttle_limit,
                       out_ch.last_motor);
          end
        end
      end
    end
  end

  // run limit
  initial begin
    #20ms;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.roll_cmd = '0;
    in_ch.pitch_cmd = '0;
    in_ch.yaw_cmd = '0;
    in_ch.throttle_cmd = '0;
    in_ch.battery_mv = '0;
    in_ch.armed = 1'b0;
    in_ch.output_enabled = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    stat.commands_sent = 0;
    stat.motors_checked = 0;
    mismatches = 0;
    hold_off = 0;
    n_loss = 0;
    n_limit = 0;
    n_disarmed = 0;
    sh_frame = 1'b0;
    sh_pmin = 12'd1000;
    sh_pmax = 12'd2000;
    sh_expo = 15'd10650;
    sh_comp_on = 1'b1;
    sh_nominal = 16'd12600;
    sh_floor = '0;
    sh_ceil = 15'd16384;
    send_idle_pct = 20;
    recv_idle_pct = 55;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    send_random(40);
    // long receiver hold-off while commands keep coming, fills the pipeline
    hold_off <= 300;
    send_random(30);
    // quad plus, linear curve, full pwm range, no compensation
    test_setting(1'b1, 12'd0, 12'd4095, 16'd0, 1'b0, 16'd12600, 16'd0, 16'd16384, 50);
    send_idle_pct = 55;
    recv_idle_pct = 20;
    // expo saturates above one, limits above one, floor above ceiling
    test_setting(1'b0, 12'd4095, 12'd0, 16'h7FFF, 1'b1, 16'hFFFF, 16'h7FFF, 16'h7FFF, 40);
    test_setting(1'b1, 12'd900, 12'd2100, 16'd16384, 1'b1, 16'd1, 16'd9000, 16'd3000, 40);
    test_setting(1'b0, 12'd1000, 12'd2000, 16'd5000, 1'b1, 16'd0, 16'd800, 16'd15000, 50);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_setting(1'b1, 12'd1100, 12'd1900, 16'd10650, 1'b1, 16'd14800, 16'd0, 16'd16384, 60);
    test_setting(1'b0, 12'd1000, 12'd2000, 16'd10650, 1'b1, 16'd12600, 16'd0, 16'd12000, 60);

    in_ch.valid <= 1'b0;
    while (motor_expect_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    $display("covered %0d commands, %0d motor transactions checked", stat.commands_sent,
             stat.motors_checked);
    $display("  thrust loss %0d, throttle limit %0d, disarmed or disabled %0d", n_loss,
             n_limit, n_disarmed);
    if (mismatches == 0 && motor_expect_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

>>> files.f
hdl/mmix_pkg.sv
hdl/mmix_in_if.sv
hdl/mmix_out_if.sv
hdl/mmix_cfg_if.sv
hdl/multirotor_motor_mixer_core.sv
dv/mmix_tb_if.sv
dv/tb_top.sv
